FILE: rtl/msd_pkg.sv
package msd_pkg;

    // field and port widths
    localparam int POS_W       = 32;
    localparam int BOX_W       = 31;
    localparam int SUM_W       = 64;
    localparam int PAIR_W      = 21;
    localparam int LAG_IN_W    = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 88;
    localparam int MAG_W       = POS_W + 1;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SQ_SHIFT    = 16;

    // divider step counts
    localparam int        DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LONG  = 7'd64;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SHORT = 7'd33;

    // command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_DIV,
        ST_SQ,
        ST_ACC,
        ST_UPD,
        ST_HIST,
        ST_QREAD,
        ST_QSTART,
        ST_QDIV,
        ST_OUT
    } msd_state_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_req_t;

    typedef struct packed {
        logic busy;
    } div_stat_t;

endpackage

FILE: rtl/msd_divider.sv
module msd_divider
    import msd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    input  logic [SUM_W-1:0]  num,
    input  logic [BOX_W-1:0]  den,
    output div_stat_t         stat,
    output logic [SUM_W-1:0]  quo,
    output logic [BOX_W-1:0]  rem
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     num_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [BOX_W-1:0]     rem_reg;
    logic [BOX_W-1:0]     den_reg;
    logic [BOX_W:0]       trial;
    logic [BOX_W:0]       sub;
    logic                 fits;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, num_reg[SUM_W-1]};
        sub   = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.short_op ? DIV_STEPS_SHORT : DIV_STEPS_LONG;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
                busy_reg <= 1'b0;
        end
    end

    // shift registers for dividend, quotient and partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? sub[BOX_W-1:0] : trial[BOX_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

FILE: rtl/msd_lag_accumulator_unit.sv
// mean squared displacement with minimum-image wrapping, one particle
// input stream: tuser carries cmd; tdata carries pos_x, pos_y, pos_z, lag.
// cmd 0 appends a position, cmd 1 queries one lag and gives one result
// on the output stream (msd_avg, pair_count, valid_res); appends give none.
// box lengths are written on the cfg channel (index 0..2), always ready.
// an append walks every stored lag in turn through one shared radix-2
// divider and one squarer: for each lag, 3 axes of a 33-step wrap
// division plus square, add and memory access; an axis with box length
// zero skips its division. a query uses one 64-step division.
// one item is processed at a time; s_axis_tready is low while busy and
// while a result waits. a stalled receiver holds the result in the
// output register and blocks further input until it is taken.
// reset clears the sample count and ring pointer; sums need no clearing
// pass, as a lag's sum is treated as zero on its first update.
module msd_lag_accumulator_unit
    import msd_pkg::*;
#(
    parameter int MAX_LAG     = 1024,
    parameter int MAX_SAMPLES = 1048576
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, pos_z, lag, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // msd_avg, pair_count, valid_res, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [BOX_W-1:0]       cfg_data
);

    localparam int AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int LW = $clog2(MAX_LAG + 1);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    msd_state_t           state_reg, state_next;
    logic [BOX_W-1:0]     box_x_reg, box_y_reg, box_z_reg;
    logic [CW-1:0]        sample_cnt_reg;
    logic [AW-1:0]        wr_ptr_reg;
    logic [LW-1:0]        lag_reg;
    logic [LW-1:0]        lag_last_reg;
    logic [1:0]           axis_reg;
    logic [POS_W-1:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [LAG_IN_W-1:0]  q_lag_reg;
    logic [CW-1:0]        q_cnt_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [SQ_W-1:0]      prod_reg;
    logic [SQ_W-1:0]      acc_reg;
    logic [SUM_W-1:0]     out_avg_reg;
    logic [PAIR_W-1:0]    out_pair_reg;
    logic                 out_valid_reg;

    logic [3*POS_W-1:0]   hist_mem [MAX_LAG];
    logic [SUM_W-1:0]     sum_mem  [MAX_LAG];
    logic [3*POS_W-1:0]   hist_rd_reg;
    logic [SUM_W-1:0]     sum_rd_reg;

    logic                 in_accept;
    logic                 in_cmd;
    logic [LAG_IN_W-1:0]  in_lag;
    logic                 q_ok;
    logic [AW-1:0]        ring_idx;
    logic [AW-1:0]        lag_addr;
    logic [AW-1:0]        q_addr;
    logic [POS_W-1:0]     h_sel, p_sel;
    logic [BOX_W-1:0]     box_sel;
    logic [MAG_W-1:0]     diff;
    logic [MAG_W-1:0]     abs_d;
    logic [MAG_W-1:0]     wrapped;
    logic [SUM_W-1:0]     old_sum;
    logic [SUM_W:0]       new_sum;
    logic [SUM_W-1:0]     sat_sum;
    logic                 first_use;

    div_req_t             div_req;
    div_stat_t            div_stat;
    logic [SUM_W-1:0]     div_num;
    logic [BOX_W-1:0]     div_den;
    logic [SUM_W-1:0]     div_quo;
    logic [BOX_W-1:0]     div_rem;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_cmd    = s_axis_tuser;
    assign in_lag    = s_axis_tdata[3*POS_W +: LAG_IN_W];
    assign cfg_ready = 1'b1;

    // query is valid for 1 <= lag <= MAX_LAG with pairs present
    assign q_ok = (in_lag != '0) && (32'(in_lag) <= 32'(MAX_LAG))
               && (32'(sample_cnt_reg) > 32'(in_lag));

    // ring slot of the sample lag_reg back, and sum addresses
    always_comb
    begin
        if (32'(wr_ptr_reg) >= 32'(lag_reg))
            ring_idx = AW'(32'(wr_ptr_reg) - 32'(lag_reg));
        else
            ring_idx = AW'(32'(wr_ptr_reg) + 32'(MAX_LAG) - 32'(lag_reg));
        lag_addr = AW'(32'(lag_reg) - 32'd1);
        q_addr   = AW'(32'(q_lag_reg) - 32'd1);
    end

    // axis select and minimum-image wrap
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                h_sel   = hist_rd_reg[0 +: POS_W];
                p_sel   = pos_x_reg;
                box_sel = box_x_reg;
            end
            AXIS_Y:
            begin
                h_sel   = hist_rd_reg[POS_W +: POS_W];
                p_sel   = pos_y_reg;
                box_sel = box_y_reg;
            end
            default:
            begin
                h_sel   = hist_rd_reg[2*POS_W +: POS_W];
                p_sel   = pos_z_reg;
                box_sel = box_z_reg;
            end
        endcase
        diff  = {h_sel[POS_W-1], h_sel} - {p_sel[POS_W-1], p_sel};
        abs_d = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
        if ({div_rem, 1'b0} >= {1'b0, box_sel})
            wrapped = MAG_W'(box_sel - div_rem);
        else
            wrapped = MAG_W'(div_rem);
    end

    // saturating update of one lag sum; first update starts from zero
    // squared distance kept modulo 2^64 before the Q.16 shift
    always_comb
    begin
        first_use = (32'(lag_reg) == 32'(sample_cnt_reg));
        old_sum   = first_use ? '0 : sum_rd_reg;
        new_sum   = {1'b0, old_sum} + (SUM_W + 1)'(acc_reg[SUM_W-1:0] >> SQ_SHIFT);
        sat_sum   = new_sum[SUM_W] ? {SUM_W{1'b1}} : new_sum[SUM_W-1:0];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        s_axis_tready    = 1'b0;
        m_axis_tvalid    = 1'b0;
        div_req.start    = 1'b0;
        div_req.short_op = 1'b0;
        div_num          = sum_rd_reg;
        div_den          = BOX_W'(q_cnt_reg);
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    if (in_cmd == CMD_QUERY)
                        state_next = q_ok ? ST_QREAD : ST_OUT;
                    else if (32'(sample_cnt_reg) >= 32'(MAX_SAMPLES))
                        state_next = ST_IDLE;
                    else if (sample_cnt_reg == '0)
                        state_next = ST_HIST;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_DIFF;
            ST_DIFF:
            begin
                if (box_sel == '0)
                    state_next = ST_SQ;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.short_op = 1'b1;
                    div_num          = {abs_d, {(SUM_W-MAG_W){1'b0}}};
                    div_den          = box_sel;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
                if (!div_stat.busy)
                    state_next = ST_SQ;
            ST_SQ:
                state_next = ST_ACC;
            ST_ACC:
                state_next = (axis_reg == AXIS_Z) ? ST_UPD : ST_DIFF;
            ST_UPD:
                state_next = (lag_reg == lag_last_reg) ? ST_HIST : ST_READ;
            ST_HIST:
                state_next = ST_IDLE;
            ST_QREAD:
                state_next = ST_QSTART;
            ST_QSTART:
            begin
                div_req.start = 1'b1;
                state_next    = ST_QDIV;
            end
            ST_QDIV:
                if (!div_stat.busy)
                    state_next = ST_OUT;
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= 31'd65536;
            box_y_reg <= 31'd65536;
            box_z_reg <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BOX_X: box_x_reg <= cfg_data;
                REG_BOX_Y: box_y_reg <= cfg_data;
                REG_BOX_Z: box_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // sample count and ring pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            wr_ptr_reg     <= '0;
        end
        else if (state_reg == ST_HIST)
        begin
            sample_cnt_reg <= sample_cnt_reg + 1'b1;
            if (32'(wr_ptr_reg) == 32'(MAX_LAG - 1))
                wr_ptr_reg <= '0;
            else
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
        end
    end

    // item capture, lag walk and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_x_reg <= s_axis_tdata[0 +: POS_W];
            pos_y_reg <= s_axis_tdata[POS_W +: POS_W];
            pos_z_reg <= s_axis_tdata[2*POS_W +: POS_W];
            q_lag_reg <= in_lag;
            q_cnt_reg <= CW'(32'(sample_cnt_reg) - 32'(in_lag));
            lag_reg   <= LW'(1);
            if (32'(sample_cnt_reg) < 32'(MAX_LAG))
                lag_last_reg <= LW'(sample_cnt_reg);
            else
                lag_last_reg <= LW'(MAX_LAG);
            if (in_cmd == CMD_QUERY && !q_ok)
            begin
                out_avg_reg   <= '0;
                out_pair_reg  <= '0;
                out_valid_reg <= 1'b0;
            end
        end
        case (state_reg)
            ST_READ:
            begin
                acc_reg  <= '0;
                axis_reg <= AXIS_X;
            end
            ST_DIFF:
                if (box_sel == '0)
                    mag_reg <= abs_d;
            ST_DIV:
                if (!div_stat.busy)
                    mag_reg <= wrapped;
            ST_SQ:
                prod_reg <= mag_reg * mag_reg;
            ST_ACC:
            begin
                acc_reg  <= acc_reg + prod_reg;
                axis_reg <= axis_reg + 1'b1;
            end
            ST_UPD:
                lag_reg <= lag_reg + 1'b1;
            ST_QDIV:
                if (!div_stat.busy)
                begin
                    out_avg_reg   <= div_quo;
                    out_pair_reg  <= PAIR_W'(q_cnt_reg);
                    out_valid_reg <= 1'b1;
                end
            default: ;
        endcase
    end

    // position ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_HIST)
            hist_mem[wr_ptr_reg] <= {pos_z_reg, pos_y_reg, pos_x_reg};
        if (state_reg == ST_READ)
            hist_rd_reg <= hist_mem[ring_idx];
    end

    // lag sums
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPD)
            sum_mem[lag_addr] <= sat_sum;
        if (state_reg == ST_READ)
            sum_rd_reg <= sum_mem[lag_addr];
        else if (state_reg == ST_QREAD)
            sum_rd_reg <= sum_mem[q_addr];
    end

    msd_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign m_axis_tdata = {2'b00, out_valid_reg, out_pair_reg, out_avg_reg};

    // no new item while a result waits
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // invalid result carries zeros
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_valid_reg) |-> (out_avg_reg == '0 && out_pair_reg == '0))
        else $error("invalid result with nonzero fields");

    // divider only started when idle
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // sample count bounded
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sample_cnt_reg) <= 32'(MAX_SAMPLES))
        else $error("sample count overflow");

    // lag walk stays within stored samples
    a_lag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (lag_reg != '0 && lag_reg <= lag_last_reg))
        else $error("lag walk out of range");

endmodule
